>>> hdl/b64u_pkg.sv
// Shared types, constants and the alphabet decode for the base64url decoder.
// No dependencies; every other file in hdl/ imports this package.
package b64u_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] PAD_CODE   = 8'h3D;
    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic        last_of_run;
        logic        end_of_stream;
        logic [15:0] byte_total;
    } t_out_item;

    // Results caused by one character, item 0 delivered first.
    typedef struct packed {
        logic [1:0]                  num;
        t_out_item [MAX_RESULTS-1:0] items;
    } t_burst;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Map one ASCII code of the URL-safe alphabet to its sextet.
    function automatic t_sextet sextet_of(logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2D) begin
            s.value = 6'd62;
        end else if (c == 8'h5F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

    function automatic t_count sat_inc(t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    // Running total as shown on the result port, pinned at all ones.
    function automatic logic [15:0] shown_total(t_count c);
        return (32'(c) > 32'(TOTAL_MAX)) ? TOTAL_MAX : 16'(c);
    endfunction

endpackage

>>> hdl/b64u_decode.sv
// Group state and per-character decode: turns one registered character into
// a burst of up to three results. Depends on b64u_pkg.
module b64u_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64u_pkg::t_in_item i_item,
    input  logic              i_fire,
    output b64u_pkg::t_burst  o_burst
);
    import b64u_pkg::*;

    logic [1:0]  r_pos,     n_pos;
    logic [17:0] r_buf,     n_buf;
    logic        r_pad3,    n_pad3;
    logic        r_bad,     n_bad;
    logic        r_discard, n_discard;
    t_count      r_count,   n_count;

    t_sextet     sx;
    logic        is_pad;
    logic        last;
    logic        grp_bad;
    logic [1:0]  nbytes;
    logic [23:0] triple;
    t_count      cnt1, cnt2, cnt3;
    t_out_item   err_item;
    t_burst      burst;

    assign sx     = sextet_of(i_item.char_code);
    assign is_pad = (i_item.char_code == PAD_CODE);
    assign last   = i_item.last_char;
    assign triple = {r_buf, sx.value};
    assign cnt1   = sat_inc(r_count);
    assign cnt2   = sat_inc(cnt1);
    assign cnt3   = sat_inc(cnt2);

    always_comb begin
        grp_bad = r_bad;
        nbytes  = 2'd0;
        if (r_pad3) begin
            if (is_pad && last) nbytes = 2'd1; else grp_bad = 1'b1;
        end else if (is_pad) begin
            if (last) nbytes = 2'd2; else grp_bad = 1'b1;
        end else if (sx.valid) begin
            nbytes = 2'd3;
        end else begin
            grp_bad = 1'b1;
        end
    end

    always_comb begin
        err_item.data_byte     = 8'd0;
        err_item.status        = ST_BAD_CHAR;
        err_item.last_of_run   = 1'b1;
        err_item.end_of_stream = 1'b1;
        err_item.byte_total    = shown_total(r_count);

        burst       = '0;
        burst.items = '0;
        n_pos     = r_pos;
        n_buf     = r_buf;
        n_pad3    = r_pad3;
        n_bad     = r_bad;
        n_discard = r_discard;
        n_count   = r_count;

        if (r_discard) begin
            if (last) begin
                n_discard = 1'b0;
                n_count   = '0;
            end
        end else if (r_pos != 2'd3) begin
            if (last) begin
                err_item.status = ST_BAD_LEN;
                burst.num      = 2'd1;
                burst.items[0] = err_item;
                n_pos   = '0;
                n_buf   = '0;
                n_pad3  = 1'b0;
                n_bad   = 1'b0;
                n_count = '0;
            end else begin
                if (is_pad && r_pos == 2'd2) begin
                    n_pad3 = 1'b1;
                    n_buf  = {r_buf[11:0], 6'd0};
                end else if (!sx.valid) begin
                    n_bad = 1'b1;
                    n_buf = {r_buf[11:0], 6'd0};
                end else begin
                    n_buf = {r_buf[11:0], sx.value};
                end
                n_pos = r_pos + 2'd1;
            end
        end else begin
            // Fourth character closes the group.
            n_pos  = '0;
            n_buf  = '0;
            n_pad3 = 1'b0;
            n_bad  = 1'b0;
            if (grp_bad) begin
                burst.num      = 2'd1;
                burst.items[0] = err_item;
                n_discard      = !last;
                if (last) n_count = '0;
            end else begin
                burst.num = nbytes;
                burst.items[0].data_byte  = triple[23:16];
                burst.items[1].data_byte  = triple[15:8];
                burst.items[2].data_byte  = triple[7:0];
                burst.items[0].byte_total = shown_total(cnt1);
                burst.items[1].byte_total = shown_total(cnt2);
                burst.items[2].byte_total = shown_total(cnt3);
                burst.items[0].status     = ST_OK;
                burst.items[1].status     = ST_OK;
                burst.items[2].status     = ST_OK;
                burst.items[0].last_of_run   = (nbytes == 2'd1);
                burst.items[1].last_of_run   = (nbytes == 2'd2);
                burst.items[2].last_of_run   = (nbytes == 2'd3);
                burst.items[0].end_of_stream = (nbytes == 2'd1) && last;
                burst.items[1].end_of_stream = (nbytes == 2'd2) && last;
                burst.items[2].end_of_stream = (nbytes == 2'd3) && last;
                case (nbytes)
                    2'd1:    n_count = cnt1;
                    2'd2:    n_count = cnt2;
                    default: n_count = cnt3;
                endcase
                if (last) n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_buf     <= '0;
            r_pad3    <= 1'b0;
            r_bad     <= 1'b0;
            r_discard <= 1'b0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_buf     <= n_buf;
            r_pad3    <= n_pad3;
            r_bad     <= n_bad;
            r_discard <= n_discard;
            r_count   <= n_count;
        end
    end

    assign o_burst = burst;

endmodule

>>> hdl/b64u_serialiser.sv
// Result register: holds a burst of up to three results and hands them out
// one per request, head slot driving the port. Depends on b64u_pkg.
module b64u_serialiser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64u_pkg::t_burst    i_burst,
    input  logic                i_load,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output b64u_pkg::t_out_item o_item
);
    import b64u_pkg::*;

    logic [1:0]                  r_cnt;
    t_out_item [MAX_RESULTS-1:0] r_slot;
    logic                        pop;

    assign pop        = (r_cnt != 2'd0) && !i_stall;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.num;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_burst.items;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[0];

endmodule

>>> hdl/base64url_padded_decoder_unit.sv
// A character accepted into the input register is decoded there; its results load into the
// result register, from which the first is taken. Throughput: one character per cycle while
// the input is not held; a closing character loads up to three bytes that drain one per cycle
// unless the output stalls, while the next group's first three characters yield nothing.
// Input is held only while a character with results waits on a result register that cannot take
// them. Reset is synchronous, active low, and returns the decoder to the start of a stream.
module base64url_padded_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  b64u_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output b64u_pkg::t_out_item o_out_item
);
    import b64u_pkg::*;

    // Input register: one character waiting for decode.
    logic     r_in_vld;
    t_in_item r_in;

    t_burst burst;
    logic   can_load;
    logic   fire;
    logic   in_free;

    // Advance the held character when it yields nothing, or when the result
    // register will be free to take its burst at this edge.
    assign fire    = r_in_vld && ((burst.num == 2'd0) || can_load);
    assign in_free = !r_in_vld || fire;

    // Hold off new requests only while the held character cannot move on.
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Group tracking, alphabet decode, padding and error rules.
    b64u_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_fire  (fire),
        .o_burst (burst)
    );

    // Results leave one per request from the result register.
    b64u_serialiser u_serialiser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .i_load     (fire && (burst.num != 2'd0)),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule

>>> bench/base64url_padded_decoder_unit_tb.sv
// Self-checking testbench for base64url_padded_decoder_unit: drives character
// requests and checks every result against a behavioural decoder kept here.
// Depends on b64u_pkg and the unit under test in hdl/.
module base64url_padded_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64u_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    localparam int RANDOM_CHARS = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Decoder state as the behavioural model sees it.
    logic [1:0]  grp_pos = '0;
    logic [17:0] sextet_acc = '0;
    logic        pad_third = 1'b0;
    logic        bad_in_group = 1'b0;
    logic        dropping = 1'b0;
    t_count      byte_count = '0;

    // Results still owed by the unit, oldest first.
    t_out_item decoded_q[$];
    t_out_item want_item;

    int live_chars = 0;
    int fail_count = 0;

    // Idling controls for both channels.
    int          send_gap_max = 0;
    int          burst_max = 1;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_phase = 0;

    base64url_padded_decoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Sextet of one character, with bit 6 set for anything outside the alphabet.
    function automatic logic [6:0] char_to_sextet(logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 26);
        if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 52);
        if (c == 8'h2D) return 7'd62;
        if (c == 8'h5F) return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] alpha_char(logic [5:0] s);
        if (s < 26) return 8'h41 + 8'(s);
        if (s < 52) return 8'h61 + 8'(s - 26);
        if (s < 62) return 8'h30 + 8'(s - 52);
        return (s == 6'd62) ? 8'h2D : 8'h5F;
    endfunction

    function automatic logic [7:0] rand_alpha();
        return alpha_char(6'($urandom_range(0, 63)));
    endfunction

    function automatic logic [15:0] total_on_port(t_count c);
        return (32'(c) > 32'(TOTAL_MAX)) ? TOTAL_MAX : 16'(c);
    endfunction

    task automatic clear_group();
        grp_pos = '0;
        sextet_acc = '0;
        pad_third = 1'b0;
        bad_in_group = 1'b0;
    endtask

    task automatic clear_stream();
        clear_group();
        dropping = 1'b0;
        byte_count = '0;
    endtask

    // Queue a single status result and either close the stream or start dropping.
    task automatic expect_error(input logic [1:0] code, input logic closing);
        t_out_item r;
        r.data_byte = 8'h00;
        r.status = code;
        r.last_of_run = 1'b1;
        r.end_of_stream = 1'b1;
        r.byte_total = total_on_port(byte_count);
        decoded_q.push_back(r);
        if (closing) begin
            clear_stream();
        end else begin
            clear_group();
            dropping = 1'b1;
        end
    endtask

    // Advance the model by one accepted character and queue what it yields.
    task automatic predict_char(input logic [7:0] code, input logic closing);
        logic [6:0]  sx;
        logic        is_pad;
        logic        bad;
        int          nbytes;
        logic [23:0] triple;
        t_out_item   r;
        sx = char_to_sextet(code);
        is_pad = (code == PAD_CODE);
        live_chars++;
        if (dropping) begin
            if (closing) clear_stream();
            return;
        end
        if (grp_pos < 2'd3) begin
            // An early end beats any character error in the same group.
            if (closing) begin
                expect_error(ST_BAD_LEN, 1'b1);
                return;
            end
            if (is_pad && grp_pos == 2'd2) begin
                pad_third = 1'b1;
                sx = '0;
            end else if (sx[6]) begin
                bad_in_group = 1'b1;
                sx = '0;
            end
            sextet_acc = {sextet_acc[11:0], sx[5:0]};
            grp_pos = grp_pos + 2'd1;
            return;
        end
        // Fourth character closes the group.
        bad = bad_in_group;
        nbytes = 0;
        if (pad_third) begin
            if (is_pad && closing) nbytes = 1;
            else bad = 1'b1;
        end else if (is_pad) begin
            if (closing) nbytes = 2;
            else bad = 1'b1;
        end else if (!sx[6]) begin
            nbytes = 3;
        end else begin
            bad = 1'b1;
        end
        if (bad) begin
            expect_error(ST_BAD_CHAR, closing);
            return;
        end
        triple = {sextet_acc, sx[5:0]};
        for (int k = 0; k < nbytes; k++) begin
            if (byte_count != '1) byte_count = byte_count + t_count'(1);
            r.data_byte = triple[23 - 8 * k -: 8];
            r.status = ST_OK;
            r.last_of_run = (k == nbytes - 1);
            r.end_of_stream = (k == nbytes - 1) && closing;
            r.byte_total = total_on_port(byte_count);
            decoded_q.push_back(r);
        end
        if (closing) clear_stream();
        else clear_group();
    endtask

    // Present one character request; hold it until the unit takes it.
    task automatic send_char(input logic [7:0] code, input logic closing);
        int gap;
        if (burst_left == 0) begin
            gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= '{char_code: code, last_char: closing};
        do @(posedge i_clk); while (o_in_stall);
        predict_char(code, closing);
    endtask

    task automatic send_text(input string s, input logic mark_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], mark_last && (i == s.len() - 1));
        end
    endtask

    // Pick fresh burst, gap and stall behaviour; called at a rising edge.
    task automatic shuffle_idling();
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        burst_max = $urandom_range(1, 10);
        stall_mode = t_stall_mode'($urandom_range(0, 2));
    endtask

    task automatic test_full_groups();
        send_gap_max = 2;
        burst_max = 3;
        stall_mode = STALL_RANDOM;
        // All-zero and all-ones bytes in one stream.
        send_text("AAAA____", 1'b1);
    endtask

    task automatic test_padding();
        send_gap_max = 0;
        stall_mode = STALL_PERIODIC;
        send_text("QQ==", 1'b1);
        send_text("QUE=", 1'b1);
    endtask

    task automatic test_char_errors();
        stall_mode = STALL_NONE;
        // Pad in first position and an out-of-alphabet code, then drop to the end.
        send_char(PAD_CODE, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("AA", 1'b0);
        send_text("Z", 1'b1);
        // Third-position pad not closing the stream, then drop the closing char.
        send_text("AB==", 1'b0);
        send_text("A", 1'b1);
    endtask

    task automatic test_length_errors();
        send_gap_max = 3;
        stall_mode = STALL_RANDOM;
        // Early end outranks the bad character in the same group.
        send_text("@B", 1'b1);
        send_text("ABC", 1'b1);
        send_text("A", 1'b1);
    endtask

    // Streams with random content, well-formed in half the cases; the rest broken or noise.
    task automatic send_random_stream();
        logic [7:0] chars[$];
        int         groups;
        int         pads;
        int         n;
        groups = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        pads = $urandom_range(0, 2);
        repeat (groups * 4) chars.push_back(rand_alpha());
        n = chars.size();
        if (pads > 0) chars[n - 1] = PAD_CODE;
        if (pads > 1) chars[n - 2] = PAD_CODE;
        case ($urandom_range(0, 7))
            0: chars[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
            1: chars[$urandom_range(0, n - 1)] = PAD_CODE;
            2: repeat ($urandom_range(1, 3)) void'(chars.pop_back());
            3: foreach (chars[i]) chars[i] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic test_random_streams();
        int start;
        start = live_chars;
        while (live_chars - start < RANDOM_CHARS) begin
            shuffle_idling();
            send_random_stream();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: stall on its own pattern, independent of the sender.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= ((stall_phase % 9) >= 6);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                $error("result with nothing expected: %h", o_out_item);
                fail_count++;
            end else begin
                want_item = decoded_q.pop_front();
                check_field("data_byte", want_item.data_byte, o_out_item.data_byte);
                check_field("status", want_item.status, o_out_item.status);
                check_field("last_of_run", want_item.last_of_run, o_out_item.last_of_run);
                check_field("end_of_stream", want_item.end_of_stream,
                            o_out_item.end_of_stream);
                check_field("byte_total", want_item.byte_total, o_out_item.byte_total);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_groups();
        test_padding();
        test_char_errors();
        test_length_errors();
        test_random_streams();
        stall_mode = STALL_NONE;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        // Drain what is owed, then keep checking for stray results before the verdict.
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/b64u_pkg.sv
hdl/b64u_decode.sv
hdl/b64u_serialiser.sv
hdl/base64url_padded_decoder_unit.sv
bench/base64url_padded_decoder_unit_tb.sv
